>>> hw/rtl/sha_pkg.sv
// Package: SHA-256 constants, payload structs and controller/datapath command types.
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_message;
   } req_word_type;

   typedef struct packed {
      logic [63:0] digest_chunk;
      logic [1:0]  chunk_index;
      logic        last_chunk;
   } rsp_word_type;

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam int unsigned LEN_POS  = 56;

   typedef logic [31:0] hash_init_type [8];
   localparam hash_init_type HASH_INIT = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   typedef logic [31:0] round_k_type [64];
   localparam round_k_type ROUND_K = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // controller -> datapath
   typedef struct packed {
      logic       load_byte;   // store byte at fill position, bump count and length
      logic       load_pad;    // store padding/length byte at fill position
      logic [7:0] pad_byte;
      logic       round_start; // copy hash into working words
      logic       round_step;  // one compression round
      logic       hash_add;    // fold working words into hash
      logic       hash_reset;  // back to initial hash, clear count and length
      logic       fill_clear;
      logic [1:0] chunk_sel;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [5:0]  fill;
      logic        last_round;
      logic [63:0] msg_len;
   } dp_status_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

>>> hw/rtl/sha_datapath.sv
// Datapath: block buffer, message schedule, round logic, hash words and length counter.
module sha_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  sha_pkg::dp_cmd_type   cmd,
   input  logic [7:0]            data_byte,
   output sha_pkg::dp_status_type status,
   output logic [63:0]           chunk
);

   // block held as 16 big-endian words, bytes land in their lane
   logic [31:0] block_ff [16];
   logic [31:0] sched_ff [16];
   logic [31:0] work_ff  [8];
   logic [31:0] hash_ff  [8];
   logic [5:0]  fill_ff;
   logic [63:0] bits_ff;
   logic [5:0]  round_ff;

   logic [4:0]  lane_lsb;
   logic [31:0] w_blk, w_sch, w_cur, s0w, s1w, t1, t2, s1, ch, s0, mj;
   logic [31:0] x15, x2;

   assign lane_lsb = {~fill_ff[1:0], 3'b000};
   assign w_blk  = block_ff[round_ff[3:0]];
   assign x15 = sched_ff[round_ff[3:0] + 4'd1];
   assign x2  = sched_ff[round_ff[3:0] + 4'd14];
   assign s0w = sha_pkg::rotr(x15, 7) ^ sha_pkg::rotr(x15, 18) ^ (x15 >> 3);
   assign s1w = sha_pkg::rotr(x2, 17) ^ sha_pkg::rotr(x2, 19) ^ (x2 >> 10);
   assign w_sch = sched_ff[round_ff[3:0]] + s0w + sched_ff[round_ff[3:0] + 4'd9] + s1w;
   assign w_cur = round_ff[5:4] == 2'd0 ? w_blk : w_sch;

   assign s1 = sha_pkg::rotr(work_ff[4], 6) ^ sha_pkg::rotr(work_ff[4], 11)
             ^ sha_pkg::rotr(work_ff[4], 25);
   assign ch = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign s0 = sha_pkg::rotr(work_ff[0], 2) ^ sha_pkg::rotr(work_ff[0], 13)
             ^ sha_pkg::rotr(work_ff[0], 22);
   assign mj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
             ^ (work_ff[1] & work_ff[2]);
   assign t1 = work_ff[7] + s1 + ch + sha_pkg::ROUND_K[round_ff] + w_cur;
   assign t2 = s0 + mj;

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         block_ff[fill_ff[5:2]][lane_lsb +: 8] <= data_byte;
      end else if (cmd.load_pad) begin
         block_ff[fill_ff[5:2]][lane_lsb +: 8] <= cmd.pad_byte;
      end
      if (cmd.round_start) begin
         for (int i = 0; i < 8; i++) work_ff[i] <= hash_ff[i];
      end else if (cmd.round_step) begin
         sched_ff[round_ff[3:0]] <= w_cur;
         for (int i = 1; i < 8; i++) work_ff[i] <= work_ff[i-1];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= sha_pkg::HASH_INIT[i];
         fill_ff  <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
      end else begin
         if (cmd.hash_reset) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= sha_pkg::HASH_INIT[i];
            bits_ff <= '0;
         end else if (cmd.hash_add) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + work_ff[i];
         end else if (cmd.load_byte) begin
            bits_ff <= bits_ff + 64'd8;
         end
         if (cmd.fill_clear || cmd.hash_reset) begin
            fill_ff <= '0;
         end else if (cmd.load_byte || cmd.load_pad) begin
            fill_ff <= fill_ff + 6'd1;
         end
         if (cmd.round_start) begin
            round_ff <= '0;
         end else if (cmd.round_step) begin
            round_ff <= round_ff + 6'd1;
         end
      end
   end

   assign status.fill       = fill_ff;
   assign status.last_round = round_ff == 6'd63;
   assign status.msg_len    = bits_ff;
   assign chunk = {hash_ff[{cmd.chunk_sel, 1'b0}], hash_ff[{cmd.chunk_sel, 1'b1}]};

endmodule

>>> hw/rtl/sha_control.sv
// Controller: sequences byte loading, padding, compression and digest output.
module sha_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sha_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sha_pkg::rsp_word_type  rsp_word,
   output sha_pkg::dp_cmd_type    cmd,
   input  sha_pkg::dp_status_type status,
   input  logic [63:0]            chunk
);

   typedef enum logic [2:0] {
      S_IDLE, S_START, S_ROUND, S_ADD, S_PAD, S_OUT
   } state_type;

   state_type   state_ff;
   logic        final_ff;   // compression belongs to the padding tail
   logic        eom_ff;     // end of message pending after a full-block compression
   logic        len_ff;     // padding block carries the length
   logic [1:0]  chunk_ff;
   logic        rsp_valid_ff;
   logic        accept;
   logic [2:0]  len_byte;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign len_byte  = status.fill[2:0];

   always_comb begin
      cmd = '0;
      cmd.chunk_sel = chunk_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_byte = accept && req_word.has_byte;
         end
         S_START: cmd.round_start = 1'b1;
         S_ROUND: cmd.round_step  = 1'b1;
         S_ADD: begin
            cmd.hash_add   = 1'b1;
            cmd.fill_clear = 1'b1;
         end
         S_PAD: begin
            cmd.load_pad = 1'b1;
            if (len_ff && status.fill >= 6'(sha_pkg::LEN_POS)) begin
               cmd.pad_byte = status.msg_len[{~len_byte, 3'b000} +: 8];
            end else if (final_ff) begin
               cmd.pad_byte = 8'h00;
            end else begin
               cmd.pad_byte = sha_pkg::PAD_BYTE;
            end
         end
         S_OUT: begin
            cmd.hash_reset = !rsp_stall && chunk_ff == 2'd3;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         final_ff     <= 1'b0;
         eom_ff       <= 1'b0;
         len_ff       <= 1'b0;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  eom_ff <= req_word.end_of_message;
                  if (req_word.has_byte && status.fill == 6'd63) begin
                     final_ff <= 1'b0;
                     state_ff <= S_START;
                  end else if (req_word.end_of_message) begin
                     final_ff <= 1'b0;
                     state_ff <= S_PAD;
                  end
               end
            end
            S_START: state_ff <= S_ROUND;
            S_ROUND: if (status.last_round) state_ff <= S_ADD;
            S_ADD: begin
               if (!final_ff) begin
                  state_ff <= eom_ff ? S_PAD : S_IDLE;
               end else if (len_ff) begin
                  rsp_valid_ff <= 1'b1;
                  chunk_ff     <= '0;
                  state_ff     <= S_OUT;
               end else begin
                  state_ff <= S_PAD;  // second block of zeros and length
               end
            end
            S_PAD: begin
               // first pad write is the marker byte
               if (!final_ff) begin
                  final_ff <= 1'b1;
                  len_ff   <= status.fill < 6'(sha_pkg::LEN_POS);
               end else if (status.fill == 6'(sha_pkg::LEN_POS - 1) && !len_ff) begin
                  len_ff <= 1'b1;
               end
               if (status.fill == 6'd63) begin
                  state_ff <= S_START;
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  chunk_ff <= chunk_ff + 2'd1;
                  if (chunk_ff == 2'd3) begin
                     rsp_valid_ff <= 1'b0;
                     final_ff     <= 1'b0;
                     eom_ff       <= 1'b0;
                     len_ff       <= 1'b0;
                     state_ff     <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_word.digest_chunk = chunk;
   assign rsp_word.chunk_index  = chunk_ff;
   assign rsp_word.last_chunk   = chunk_ff == 2'd3;

endmodule

>>> hw/rtl/sha256_stream_hasher_core.sv
// SHA-256 stream hasher top level.
// Usage: one word on req carries an optional message byte (has_byte) and an
// end_of_message flag. Bytes fill a 64-byte block buffer one per cycle; when
// the buffer is full the block is compressed by a single round unit, one
// round per cycle, and req_stall is held high meanwhile.
// A plain byte word leaves req_stall low; the word that completes a block
// is followed by start, 64 rounds and hash add.
// End of message: padding is written one byte a cycle to the end of the
// block, followed by one or two compressions, then four rsp words of 64
// bits, most significant first, last_chunk on the fourth.
// One compression serves when marker and length fit the block, two otherwise.
// rsp_stall holds the current digest word in place; no new req word is
// taken until the last digest word has gone.
// Reset: synchronous, restores the initial hash, clears the byte count and
// bit length, and returns the controller to idle.
module sha256_stream_hasher_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sha_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sha_pkg::rsp_word_type rsp_word
);

   sha_pkg::dp_cmd_type    cmd;
   sha_pkg::dp_status_type status;
   logic [63:0]            chunk;

   sha_control u_control (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .rsp_valid, .rsp_stall, .rsp_word, .cmd, .status, .chunk
   );

   sha_datapath u_datapath (
      .clock, .reset, .cmd, .data_byte(req_word.data_byte), .status, .chunk
   );

endmodule
